@@ rtl/tank_level_sensor_monitor_macros.svh @@
// assertion macros for the tank level sensor monitor
`ifndef TANK_LEVEL_SENSOR_MONITOR_MACROS_SVH
`define TANK_LEVEL_SENSOR_MONITOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLSM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlsm assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TLSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlsm assertion failed");

`endif

@@ rtl/tlsm_pkg.sv @@
// shared constants, widths and types of the tank level sensor monitor
package tlsm_pkg;

    // averaging depth and the channel that runs the health check
    localparam int SAMPLES = 8;
    localparam logic MAIN_CHANNEL = 1'b0;

    // field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int MAG_W = SUM_W;
    localparam int PCT_W = 14;
    localparam int UNC_W = 17;
    localparam int NUM_W = MAG_W + PCT_W;
    localparam int QUO_W = 16;
    localparam int STEP_W = $clog2(QUO_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TIME_W = 32;

    // arithmetic constants
    localparam logic signed [SUM_W:0] SAMPLES_OFS = (SUM_W + 1)'(SAMPLES);
    localparam logic signed [UNC_W-1:0] MIN_SPAN = 17'sd8;
    localparam logic signed [UNC_W-1:0] UNC_SAT = 17'sd50000;
    localparam logic [QUO_W-1:0] QUO_SAT = 16'd50000;
    localparam logic [QUO_W-1:0] QUO_FULL = 16'd10000;
    localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;
    localparam int PCT_SCALE = 10000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_CH0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CH1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_CH1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_EPS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_TIME = 3'd7;

    // register reset values
    localparam logic signed [15:0] RST_EMPTY = 16'sd0;
    localparam logic signed [15:0] RST_FULL = 16'sd26400;
    localparam logic signed [UNC_W-1:0] RST_VALID_LOW = -17'sd1000;
    localparam logic signed [UNC_W-1:0] RST_VALID_HIGH = 17'sd11000;
    localparam logic [PCT_W-1:0] RST_STUCK_EPS = 14'd100;
    localparam logic [TIME_W-1:0] RST_STUCK_TIME = 32'd60000;

    // health status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_STABLE = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // divider control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
        logic check;
    } div_ctrl_t;

endpackage

@@ rtl/tlsm_div.sv @@
// shared restoring divider: one quotient bit per step, plus an overflow check
module tlsm_div (
    input  logic                         clk,
    input  tlsm_pkg::div_ctrl_t          ctrl,
    input  logic [tlsm_pkg::NUM_W-1:0]   load_value,
    input  logic [tlsm_pkg::MAG_W-1:0]   den,
    output logic [tlsm_pkg::QUO_W-1:0]   quo,
    output logic                         fits
);

    logic [tlsm_pkg::MAG_W:0]   rem_reg;
    logic [tlsm_pkg::QUO_W-1:0] low_reg;
    logic [tlsm_pkg::MAG_W:0]   operand;
    logic [tlsm_pkg::MAG_W+1:0] trial;

    // the check compares the loaded high part, a step shifts in the next bit
    assign operand = ctrl.check ? rem_reg
                                : {rem_reg[tlsm_pkg::MAG_W-1:0],
                                   low_reg[tlsm_pkg::QUO_W-1]};
    assign trial = {1'b0, operand} - {2'b00, den};
    assign fits = !trial[tlsm_pkg::MAG_W+1];
    assign quo = low_reg;

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= (tlsm_pkg::MAG_W + 1)'(
                load_value[tlsm_pkg::NUM_W-1:tlsm_pkg::QUO_W]);
            low_reg <= load_value[tlsm_pkg::QUO_W-1:0];
        end
        else if (ctrl.step)
        begin
            rem_reg <= fits ? trial[tlsm_pkg::MAG_W:0] : operand;
            low_reg <= {low_reg[tlsm_pkg::QUO_W-2:0], fits};
        end
    end

endmodule

@@ rtl/tank_level_sensor_monitor.sv @@
// tank level sensor monitor top level: averaging, level mapping, health check
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_ready   sample, channel, adc_ready, now_ms
// out      source     out_valid / out_ready out_channel, avg_code, level_pct,
//                                           health_status, healthy
// cfg      sink       cfg_we                cfg_index, cfg_wdata
//
// a beat that only accumulates leaves the sequencer in idle, ready for the next beat; a
// converter-missing beat goes to the final state, which registers its result and returns to idle
// a beat that completes an average runs setup, a 16-step pass of the shared restoring
// divider for the average, multiply, overflow check, a 16-step level pass and the check
// a narrow span skips the overflow check and the level pass, a saturated level the level pass
// rst_n clears the accumulators, the reference and the status at once
// the output register holds a result while out_ready is low; the next beat is taken
// meanwhile, and a later result waits in the final state
`include "tank_level_sensor_monitor_macros.svh"

module tank_level_sensor_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tlsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  sample,
    input  logic                                channel,
    input  logic                                adc_ready,
    input  logic [31:0]                         now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_channel,
    output logic signed [15:0]                  avg_code,
    output logic [13:0]                         level_pct,
    output logic [1:0]                          health_status,
    output logic                                healthy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_AVG    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_OVF    = 4'd4;
    localparam logic [3:0] S_LVL    = 4'd5;
    localparam logic [3:0] S_LVLEND = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic [tlsm_pkg::STEP_W-1:0] STEP_LAST =
        tlsm_pkg::STEP_W'(tlsm_pkg::QUO_W - 1);

    // configuration registers
    logic signed [15:0]                 empty0_reg, full0_reg, empty1_reg, full1_reg;
    logic signed [tlsm_pkg::UNC_W-1:0]  valid_low_reg, valid_high_reg;
    logic [tlsm_pkg::PCT_W-1:0]         stuck_eps_reg;
    logic [tlsm_pkg::TIME_W-1:0]        stuck_time_reg;

    // control and accumulator state
    logic [3:0]                         state_reg, state_next;
    logic [tlsm_pkg::STEP_W-1:0]        step_cnt_reg;
    logic signed [tlsm_pkg::SUM_W-1:0]  sum_reg [2];
    logic [tlsm_pkg::CNT_W-1:0]         cnt_reg [2];
    logic [tlsm_pkg::PCT_W-1:0]         ref_pct_reg;
    logic [tlsm_pkg::TIME_W-1:0]        ref_time_reg;
    logic                               ref_valid_reg;
    logic [1:0]                         last_status_reg;
    logic                               out_valid_reg;

    // item payload
    logic signed [tlsm_pkg::SUM_W-1:0]  sum_cur_reg;
    logic                               ch_reg;
    logic [tlsm_pkg::TIME_W-1:0]        now_reg;
    logic [tlsm_pkg::MAG_W-1:0]         off_mag_reg;
    logic [tlsm_pkg::MAG_W-1:0]         den_reg;
    logic                               q_neg_reg;
    logic                               sum_neg_reg;
    logic                               narrow_reg;
    logic signed [tlsm_pkg::UNC_W-1:0]  unc_reg;
    logic [tlsm_pkg::PCT_W-1:0]         lvl_reg;
    logic signed [15:0]                 res_avg_reg;
    logic [1:0]                         res_status_reg;
    logic                               out_ch_reg;
    logic signed [15:0]                 out_avg_reg;
    logic [tlsm_pkg::PCT_W-1:0]         out_lvl_reg;
    logic [1:0]                         out_status_reg;

    // combinational
    logic                               accept;
    logic                               last_sample;
    logic signed [tlsm_pkg::SUM_W-1:0]  sum_add;
    logic signed [15:0]                 empty_sel, full_sel;
    logic signed [tlsm_pkg::UNC_W-1:0]  span;
    logic [15:0]                        span_mag;
    logic                               narrow;
    logic signed [tlsm_pkg::SUM_W:0]    off;
    logic [tlsm_pkg::MAG_W-1:0]         off_mag;
    logic [tlsm_pkg::MAG_W-1:0]         sum_mag;
    tlsm_pkg::div_ctrl_t                div_ctrl;
    logic [tlsm_pkg::NUM_W-1:0]         div_load;
    logic [tlsm_pkg::MAG_W-1:0]         div_den;
    logic [tlsm_pkg::QUO_W-1:0]         quo;
    logic                               fits;
    logic [tlsm_pkg::QUO_W-1:0]         quo_sat;
    logic                               range_fail;
    logic [tlsm_pkg::PCT_W-1:0]         ref_pct_eff;
    logic [tlsm_pkg::TIME_W-1:0]        ref_time_eff;
    logic [tlsm_pkg::PCT_W-1:0]         diff;
    logic                               moved;
    logic                               stale;
    logic                               out_free;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // accumulate path for the incoming beat
    assign sum_add = sum_reg[channel]
                   + $signed({{(tlsm_pkg::SUM_W - 16){sample[15]}}, sample});
    assign last_sample = (cnt_reg[channel] == tlsm_pkg::CNT_W'(tlsm_pkg::SAMPLES - 1));

    // span and offset of the completed average
    assign empty_sel = ch_reg ? empty1_reg : empty0_reg;
    assign full_sel = ch_reg ? full1_reg : full0_reg;
    assign span = {full_sel[15], full_sel} - {empty_sel[15], empty_sel};
    assign span_mag = span[tlsm_pkg::UNC_W-1] ? 16'(-span) : span[15:0];
    assign narrow = (span > -tlsm_pkg::MIN_SPAN) && (span < tlsm_pkg::MIN_SPAN);
    assign off = {sum_cur_reg[tlsm_pkg::SUM_W-1], sum_cur_reg}
               - $signed({{(tlsm_pkg::SUM_W + 1 - 16){empty_sel[15]}}, empty_sel})
                 * tlsm_pkg::SAMPLES_OFS;
    assign off_mag = off[tlsm_pkg::SUM_W] ? tlsm_pkg::MAG_W'(-off)
                                          : off[tlsm_pkg::MAG_W-1:0];
    assign sum_mag = sum_cur_reg[tlsm_pkg::SUM_W-1] ? tlsm_pkg::MAG_W'(-sum_cur_reg)
                                                    : tlsm_pkg::MAG_W'(sum_cur_reg);

    // divider operands and control
    always_comb
    begin
        div_ctrl.load = (state_reg == S_SETUP) || ((state_reg == S_MUL) && !narrow_reg);
        div_ctrl.step = (state_reg == S_AVG) || (state_reg == S_LVL);
        div_ctrl.check = (state_reg == S_OVF);
        if (state_reg == S_SETUP)
        begin
            div_load = tlsm_pkg::NUM_W'(sum_mag);
        end
        else
        begin
            div_load = tlsm_pkg::NUM_W'(off_mag_reg)
                     * tlsm_pkg::NUM_W'(tlsm_pkg::PCT_SCALE);
        end
        div_den = (state_reg == S_AVG) ? tlsm_pkg::MAG_W'(tlsm_pkg::SAMPLES) : den_reg;
    end

    tlsm_div u_div (
        .clk        (clk),
        .ctrl       (div_ctrl),
        .load_value (div_load),
        .den        (div_den),
        .quo        (quo),
        .fits       (fits)
    );

    assign quo_sat = (quo > tlsm_pkg::QUO_SAT) ? tlsm_pkg::QUO_SAT : quo;

    // health check terms
    assign range_fail = (unc_reg < valid_low_reg) || (unc_reg > valid_high_reg);
    assign ref_pct_eff = ref_valid_reg ? ref_pct_reg : lvl_reg;
    assign ref_time_eff = ref_valid_reg ? ref_time_reg : now_reg;
    assign diff = (lvl_reg > ref_pct_eff) ? (lvl_reg - ref_pct_eff)
                                          : (ref_pct_eff - lvl_reg);
    assign moved = diff > stuck_eps_reg;
    assign stale = (now_reg - ref_time_eff) > stuck_time_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty0_reg <= tlsm_pkg::RST_EMPTY;
            full0_reg <= tlsm_pkg::RST_FULL;
            empty1_reg <= tlsm_pkg::RST_EMPTY;
            full1_reg <= tlsm_pkg::RST_FULL;
            valid_low_reg <= tlsm_pkg::RST_VALID_LOW;
            valid_high_reg <= tlsm_pkg::RST_VALID_HIGH;
            stuck_eps_reg <= tlsm_pkg::RST_STUCK_EPS;
            stuck_time_reg <= tlsm_pkg::RST_STUCK_TIME;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tlsm_pkg::REG_EMPTY_CH0:  empty0_reg <= cfg_wdata[15:0];
                tlsm_pkg::REG_FULL_CH0:   full0_reg <= cfg_wdata[15:0];
                tlsm_pkg::REG_EMPTY_CH1:  empty1_reg <= cfg_wdata[15:0];
                tlsm_pkg::REG_FULL_CH1:   full1_reg <= cfg_wdata[15:0];
                tlsm_pkg::REG_VALID_LOW:  valid_low_reg <= cfg_wdata[tlsm_pkg::UNC_W-1:0];
                tlsm_pkg::REG_VALID_HIGH: valid_high_reg <= cfg_wdata[tlsm_pkg::UNC_W-1:0];
                tlsm_pkg::REG_STUCK_EPS:  stuck_eps_reg <= cfg_wdata[tlsm_pkg::PCT_W-1:0];
                tlsm_pkg::REG_STUCK_TIME: stuck_time_reg <= cfg_wdata[tlsm_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!adc_ready)
                    begin
                        state_next = S_DONE;
                    end
                    else if (last_sample)
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:  state_next = S_AVG;
            S_AVG:    state_next = (step_cnt_reg == STEP_LAST) ? S_MUL : S_AVG;
            S_MUL:    state_next = narrow_reg ? S_CHECK : S_OVF;
            S_OVF:    state_next = fits ? S_CHECK : S_LVL;
            S_LVL:    state_next = (step_cnt_reg == STEP_LAST) ? S_LVLEND : S_LVL;
            S_LVLEND: state_next = S_CHECK;
            S_CHECK:  state_next = S_DONE;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control state: sequencer, step counter, accumulators, reference, status, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_cnt_reg <= '0;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            ref_pct_reg <= '0;
            ref_time_reg <= '0;
            ref_valid_reg <= 1'b0;
            last_status_reg <= tlsm_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // step counter runs through both divider passes
            if ((state_reg == S_AVG) || (state_reg == S_LVL))
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end

            // per-channel accumulate, cleared on a missing converter or a full set
            if (accept)
            begin
                if (!adc_ready || last_sample)
                begin
                    sum_reg[channel] <= '0;
                    cnt_reg[channel] <= '0;
                end
                else
                begin
                    sum_reg[channel] <= sum_add;
                    cnt_reg[channel] <= cnt_reg[channel] + 1'b1;
                end
                if (!adc_ready)
                begin
                    last_status_reg <= tlsm_pkg::ST_MISSING;
                end
            end

            // health check on the main channel
            if ((state_reg == S_CHECK) && (ch_reg == tlsm_pkg::MAIN_CHANNEL))
            begin
                if (range_fail)
                begin
                    last_status_reg <= tlsm_pkg::ST_RANGE;
                end
                else
                begin
                    ref_valid_reg <= 1'b1;
                    if (!ref_valid_reg || moved)
                    begin
                        ref_pct_reg <= lvl_reg;
                        ref_time_reg <= now_reg;
                    end
                    last_status_reg <= (!moved && stale) ? tlsm_pkg::ST_STABLE
                                                         : tlsm_pkg::ST_OK;
                end
            end

            // output register
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_reg <= channel;
                    now_reg <= now_ms;
                    sum_cur_reg <= sum_add;
                    res_avg_reg <= '0;
                    lvl_reg <= '0;
                    res_status_reg <= tlsm_pkg::ST_MISSING;
                end
            end
            S_SETUP:
            begin
                off_mag_reg <= off_mag;
                den_reg <= tlsm_pkg::MAG_W'(span_mag) * tlsm_pkg::MAG_W'(tlsm_pkg::SAMPLES);
                q_neg_reg <= off[tlsm_pkg::SUM_W] ^ span[tlsm_pkg::UNC_W-1];
                sum_neg_reg <= sum_cur_reg[tlsm_pkg::SUM_W-1];
                narrow_reg <= narrow;
            end
            S_AVG: ;
            S_MUL:
            begin
                res_avg_reg <= sum_neg_reg ? 16'(-quo) : quo;
                unc_reg <= '0;
                lvl_reg <= '0;
            end
            S_OVF:
            begin
                unc_reg <= q_neg_reg ? -tlsm_pkg::UNC_SAT : tlsm_pkg::UNC_SAT;
                lvl_reg <= q_neg_reg ? '0 : tlsm_pkg::PCT_FULL;
            end
            S_LVL: ;
            S_LVLEND:
            begin
                unc_reg <= q_neg_reg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
                if (q_neg_reg)
                begin
                    lvl_reg <= '0;
                end
                else if (quo > tlsm_pkg::QUO_FULL)
                begin
                    lvl_reg <= tlsm_pkg::PCT_FULL;
                end
                else
                begin
                    lvl_reg <= quo[tlsm_pkg::PCT_W-1:0];
                end
            end
            S_CHECK:
            begin
                if (ch_reg != tlsm_pkg::MAIN_CHANNEL)
                begin
                    res_status_reg <= last_status_reg;
                end
                else if (range_fail)
                begin
                    res_status_reg <= tlsm_pkg::ST_RANGE;
                end
                else
                begin
                    res_status_reg <= (!moved && stale) ? tlsm_pkg::ST_STABLE
                                                        : tlsm_pkg::ST_OK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_ch_reg <= ch_reg;
                    out_avg_reg <= res_avg_reg;
                    out_lvl_reg <= lvl_reg;
                    out_status_reg <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign avg_code = out_avg_reg;
    assign level_pct = out_lvl_reg;
    assign health_status = out_status_reg;
    assign healthy = (out_status_reg == tlsm_pkg::ST_OK)
                  || (out_status_reg == tlsm_pkg::ST_STABLE);

    // checks; a missing status on the other channel can also repeat the last status
    `TLSM_ASSERT_IMPL(a_lvl_clamped, out_valid_reg, out_lvl_reg <= tlsm_pkg::PCT_FULL)
    `TLSM_ASSERT_IMPL(a_missing_zero,
        out_valid_reg && (out_ch_reg == tlsm_pkg::MAIN_CHANNEL)
            && (out_status_reg == tlsm_pkg::ST_MISSING),
        (out_avg_reg == 16'sd0) && (out_lvl_reg == '0))
    `TLSM_ASSERT_IMPL(a_step_in_pass, step_cnt_reg != '0, (state_reg == S_AVG) || (state_reg == S_LVL))
    `TLSM_ASSERT_NEXT(a_missing_done, accept && !adc_ready, state_reg == S_DONE)
    `TLSM_ASSERT_NEXT(a_ref_sticky, ref_valid_reg, ref_valid_reg)

endmodule
